// ===== design/swmmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmmm_pkg
// Shared widths, reset constants and the control state type of the
// sliding-window min/max/mean core.
// ----------------------------------------------------------------------------
package swmmm_pkg;

  // Payload widths
  localparam int SPEED_W = 10;
  localparam int LEN_W   = 5;

  // Default window storage and reset window length
  localparam int MAX_WINDOW_DEF      = 16;
  localparam int RESET_WINDOW_LENGTH = 12;

  typedef logic [SPEED_W-1:0] speed_t;
  typedef logic [LEN_W-1:0]   len_t;

  localparam speed_t SPEED_MAX = '1;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== design/swmmm_if.sv =====
// ----------------------------------------------------------------------------
// swmmm channel interfaces
// Valid/ready channels for the sample input and the statistics output.
// ----------------------------------------------------------------------------

// Sample channel: one speed sample per transfer
interface swmmm_sample_if;
  logic              valid;
  logic              ready;
  swmmm_pkg::speed_t speed;

  modport source (output valid, output speed, input ready);
  modport sink   (input valid, input speed, output ready);
endinterface

// Statistics channel: one result per transfer
interface swmmm_stats_if;
  logic              valid;
  logic              ready;
  swmmm_pkg::speed_t max_speed;
  swmmm_pkg::speed_t min_speed;
  swmmm_pkg::speed_t mean_speed;
  swmmm_pkg::len_t   samples_held;

  modport source (output valid, output max_speed, output min_speed,
                  output mean_speed, output samples_held, input ready);
  modport sink   (input valid, input max_speed, input min_speed,
                  input mean_speed, input samples_held, output ready);
endinterface

// ===== design/swmmm_ram.sv =====
// ----------------------------------------------------------------------------
// swmmm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module swmmm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/swmmm_div.sv =====
// ----------------------------------------------------------------------------
// swmmm_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient
// holds after the last step until the next start.
// ----------------------------------------------------------------------------
module swmmm_div #(
  parameter int NUM_W = 15,
  parameter int DEN_W = 5,
  parameter int QUO_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    diff    = shifted - {1'b0, den};
    ge      = (shifted >= {1'b0, den});
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: dividend shifts out at the top, quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= denom;
      quo <= numer;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign done     = !busy;
  assign quotient = quo[QUO_W-1:0];

endmodule

// ===== design/sliding_window_min_max_mean_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_core
// Keeps the latest window_length speed samples in a ring RAM and reports
// max, min, truncated mean and count after every inserted sample.
// ----------------------------------------------------------------------------
// A result is ready once the bit-serial mean divider (one bit per cycle over
//   the sum width) and the ring scan (one RAM read per cycle) are both done.
//   One sample in flight: the next is taken only after the result is loaded.
// A finished result waits in the output register; the next result, and so
//   the input, stall in ST_FINISH until that register is taken or empty.
// Reset: empty window, window_length = 12; a window_length write empties it.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_core #(
  parameter int MAX_WINDOW = swmmm_pkg::MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  swmmm_pkg::len_t       cfg_wdata,
  swmmm_sample_if.sink          sample,
  swmmm_stats_if.source         stats
);

  localparam int IDX_W   = $clog2(MAX_WINDOW);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = swmmm_pkg::SPEED_W + CNT_W;
  localparam int LW      = (CNT_W > swmmm_pkg::LEN_W) ? CNT_W : swmmm_pkg::LEN_W;
  localparam int RST_LEN = (swmmm_pkg::RESET_WINDOW_LENGTH > MAX_WINDOW) ?
                           MAX_WINDOW : swmmm_pkg::RESET_WINDOW_LENGTH;

  swmmm_pkg::state_t state, state_next;

  // Window state
  logic [CNT_W-1:0]  len_eff;
  logic [IDX_W-1:0]  write_slot;
  logic [CNT_W-1:0]  held_count;
  logic [SUM_W-1:0]  running_sum;

  // Current sample
  swmmm_pkg::speed_t cur_speed;
  logic [IDX_W-1:0]  cur_slot;
  logic              cur_full;

  // Scan
  logic [CNT_W-1:0]  scan_addr;
  logic              rd_pend;
  swmmm_pkg::speed_t hi;
  swmmm_pkg::speed_t lo;

  // Output register
  logic              out_valid;
  swmmm_pkg::speed_t out_max;
  swmmm_pkg::speed_t out_min;
  swmmm_pkg::speed_t out_mean;
  swmmm_pkg::len_t   out_held;

  // Combinational
  logic [LW-1:0]     cfg_ext;
  logic [CNT_W-1:0]  cfg_len;
  logic [IDX_W-1:0]  slot_calc;
  logic              full_calc;
  swmmm_pkg::speed_t old_sample;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  count_new;
  logic [CNT_W-1:0]  slot_inc;
  logic [IDX_W-1:0]  slot_new;
  logic              accept;
  logic              scan_issue;
  logic              out_load;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  swmmm_pkg::speed_t ram_rdata;
  logic              div_start;
  logic              div_done;
  swmmm_pkg::speed_t div_quo;

  // Window length clamp: zero means one, above storage saturates
  always_comb begin
    cfg_ext = LW'(cfg_wdata);
    if (cfg_ext == '0) begin
      cfg_len = CNT_W'(1);
    end else if (cfg_ext > LW'(MAX_WINDOW)) begin
      cfg_len = CNT_W'(MAX_WINDOW);
    end else begin
      cfg_len = cfg_ext[CNT_W-1:0];
    end
  end

  // Insertion arithmetic
  always_comb begin
    slot_calc  = (CNT_W'(write_slot) >= len_eff) ? '0 : write_slot;
    full_calc  = (held_count >= len_eff);
    old_sample = cur_full ? ram_rdata : '0;
    sum_new    = running_sum - SUM_W'(old_sample) + SUM_W'(cur_speed);
    count_new  = cur_full ? len_eff : held_count + 1'b1;
    slot_inc   = CNT_W'(cur_slot) + 1'b1;
    slot_new   = (slot_inc >= len_eff) ? '0 : slot_inc[IDX_W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      swmmm_pkg::ST_IDLE:   if (sample.valid) state_next = swmmm_pkg::ST_UPDATE;
      swmmm_pkg::ST_UPDATE: state_next = swmmm_pkg::ST_SCAN;
      swmmm_pkg::ST_SCAN:   if (!scan_issue && !rd_pend) state_next = swmmm_pkg::ST_FINISH;
      swmmm_pkg::ST_FINISH: if (out_load) state_next = swmmm_pkg::ST_IDLE;
      default:              state_next = swmmm_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    sample.ready = (state == swmmm_pkg::ST_IDLE);
    accept       = sample.valid && sample.ready;
    ram_we       = (state == swmmm_pkg::ST_UPDATE);
    div_start    = (state == swmmm_pkg::ST_UPDATE);
    scan_issue   = (state == swmmm_pkg::ST_SCAN) && (scan_addr < held_count);
    out_load     = (state == swmmm_pkg::ST_FINISH) && div_done &&
                   (!out_valid || stats.ready);
    ram_raddr    = (state == swmmm_pkg::ST_IDLE) ? slot_calc : scan_addr[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window bookkeeping; a length write empties the window
  always_ff @(posedge clk) begin
    if (rst) begin
      len_eff     <= CNT_W'(RST_LEN);
      write_slot  <= '0;
      held_count  <= '0;
      running_sum <= '0;
    end else if (cfg_we) begin
      len_eff     <= cfg_len;
      write_slot  <= '0;
      held_count  <= '0;
      running_sum <= '0;
    end else if (ram_we) begin
      write_slot  <= slot_new;
      held_count  <= count_new;
      running_sum <= sum_new;
    end
  end

  // Capture sample; oldest entry is read during the transfer cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_speed <= sample.speed;
      cur_slot  <= slot_calc;
      cur_full  <= full_calc;
    end
  end

  // Ring scan: one read per cycle, each compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      scan_addr <= '0;
      hi        <= '0;
      lo        <= swmmm_pkg::SPEED_MAX;
    end else begin
      if (scan_issue) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (rd_pend) begin
        if (ram_rdata > hi) hi <= ram_rdata;
        if (ram_rdata < lo) lo <= ram_rdata;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (stats.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_max  <= hi;
      out_min  <= lo;
      out_mean <= div_quo;
      out_held <= swmmm_pkg::LEN_W'(held_count);
    end
  end

  assign stats.valid        = out_valid;
  assign stats.max_speed    = out_max;
  assign stats.min_speed    = out_min;
  assign stats.mean_speed   = out_mean;
  assign stats.samples_held = out_held;

  // Sample ring
  swmmm_ram #(
    .WIDTH (swmmm_pkg::SPEED_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_slot),
    .wdata (cur_speed),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Mean divider, runs alongside the scan
  swmmm_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W),
    .QUO_W (swmmm_pkg::SPEED_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (sum_new),
    .denom    (count_new),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

// ===== sim/tb_sliding_window_min_max_mean_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max_mean_core
// Self-checking bench for the sliding-window min/max/mean core. A small window
// tracker mirrors the ring, count and running sum. It predicts one statistics
// result per accepted sample, and each accepted result is checked in order.
// The bench steps through several window lengths, including zero and
// oversized values. Both channels idle at random, and there are two long
// output hold-offs.
// ----------------------------------------------------------------------------
module tb_sliding_window_min_max_mean_core;

  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 50;

  typedef struct packed {
    swmmm_pkg::speed_t max_speed;
    swmmm_pkg::speed_t min_speed;
    swmmm_pkg::speed_t mean_speed;
    swmmm_pkg::len_t   samples_held;
  } stats_t;

  // Window tracker: mirrors the core state and holds the results still due
  class window_stats_tracker;
    swmmm_pkg::speed_t ring [swmmm_pkg::MAX_WINDOW_DEF];
    int unsigned       slot;
    int unsigned       held;
    logic [13:0]       total;
    swmmm_pkg::len_t   window_reg;
    stats_t            stats_due [$];
    int                errors;

    function new();
      window_reg = swmmm_pkg::len_t'(swmmm_pkg::RESET_WINDOW_LENGTH);
      slot       = 0;
      held       = 0;
      total      = '0;
      errors     = 0;
    endfunction

    // A length write empties the window
    function void set_window(swmmm_pkg::len_t len);
      window_reg = len;
      slot       = 0;
      held       = 0;
      total      = '0;
    endfunction

    function int pending();
      return stats_due.size();
    endfunction

    // Insert one sample and queue the statistics it produces
    function void take_sample(swmmm_pkg::speed_t s);
      int unsigned eff;
      int unsigned pos;
      stats_t      res;
      eff = window_reg;
      if (eff < 1) eff = 1;
      if (eff > swmmm_pkg::MAX_WINDOW_DEF) eff = swmmm_pkg::MAX_WINDOW_DEF;
      pos = (slot >= eff) ? 0 : slot;
      if (held >= eff) begin
        total = total - 14'(ring[pos]);
        held  = eff;
      end else begin
        held++;
      end
      ring[pos] = s;
      total     = total + 14'(s);
      slot      = (pos + 1 >= eff) ? 0 : pos + 1;
      res.max_speed = '0;
      res.min_speed = swmmm_pkg::SPEED_MAX;
      for (int i = 0; i < held; i++) begin
        if (ring[i] > res.max_speed) res.max_speed = ring[i];
        if (ring[i] < res.min_speed) res.min_speed = ring[i];
      end
      res.mean_speed   = swmmm_pkg::speed_t'(total / held);
      res.samples_held = swmmm_pkg::len_t'(held);
      stats_due.push_back(res);
    endfunction

    task flag_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_stats(stats_t got);
      stats_t want;
      if (stats_due.size() == 0) begin
        flag_mismatch($sformatf("stats transfer with nothing expected (max %0d min %0d)",
                                got.max_speed, got.min_speed));
      end else begin
        want = stats_due.pop_front();
        if (got.max_speed !== want.max_speed)
          flag_mismatch($sformatf("max_speed %0d, expected %0d",
                                  got.max_speed, want.max_speed));
        if (got.min_speed !== want.min_speed)
          flag_mismatch($sformatf("min_speed %0d, expected %0d",
                                  got.min_speed, want.min_speed));
        if (got.mean_speed !== want.mean_speed)
          flag_mismatch($sformatf("mean_speed %0d, expected %0d",
                                  got.mean_speed, want.mean_speed));
        if (got.samples_held !== want.samples_held)
          flag_mismatch($sformatf("samples_held %0d, expected %0d",
                                  got.samples_held, want.samples_held));
      end
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_we;
  swmmm_pkg::len_t cfg_wdata;
  bit              steady;
  int              hold_cycles;
  int              cycle_count;

  window_stats_tracker tracker;

  swmmm_sample_if sample_ch ();
  swmmm_stats_if  stats_ch ();

  sliding_window_min_max_mean_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (sample_ch),
    .stats     (stats_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sliding_window_min_max_mean_core: FAILED **");
      $finish;
    end
  end

  // Output ready: long hold-off when requested, else random or always ready
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      stats_ch.ready <= 1'b0;
      hold_cycles--;
    end else if (steady) begin
      stats_ch.ready <= 1'b1;
    end else begin
      stats_ch.ready <= ($urandom_range(99) >= 37);
    end
  end

  // Check every accepted stats transfer
  always @(posedge clk) begin
    if (!rst && stats_ch.valid && stats_ch.ready)
      tracker.check_stats('{stats_ch.max_speed, stats_ch.min_speed,
                            stats_ch.mean_speed, stats_ch.samples_held});
  end

  // Offer one sample with random idle gaps and hold it until the transfer
  task send_speed(input swmmm_pkg::speed_t v);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 37) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.speed <= v;
    do @(posedge clk); while (!sample_ch.ready);
    tracker.take_sample(v);
  endtask

  // Stop offering and wait for every expected result
  task drain;
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task write_window(input swmmm_pkg::len_t len);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    tracker.set_window(len);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly uniform samples, with extremes and near-extremes mixed in
  function automatic swmmm_pkg::speed_t rand_speed();
    case ($urandom_range(9))
      0:       return '0;
      1:       return swmmm_pkg::SPEED_MAX;
      2:       return swmmm_pkg::speed_t'($urandom_range(15));
      3:       return swmmm_pkg::speed_t'($urandom_range(1023, 1008));
      default: return swmmm_pkg::speed_t'($urandom_range(1023));
    endcase
  endfunction

  initial begin
    swmmm_pkg::speed_t directed_speeds [16];
    swmmm_pkg::len_t   phase_len [11];

    directed_speeds = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd1022, 10'd512,
                        10'd511, 10'd0, 10'd1023, 10'd7, 10'd300, 10'd1023, 10'd0,
                        10'd5, 10'd999};
    // Zero and oversized lengths, the extremes, then random settings
    phase_len = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd2, 5'd17, 5'd15,
                  swmmm_pkg::len_t'($urandom_range(31)),
                  swmmm_pkg::len_t'($urandom_range(16, 3)),
                  swmmm_pkg::len_t'($urandom_range(31)), 5'd16};

    tracker         = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    sample_ch.valid = 1'b0;
    sample_ch.speed = '0;
    stats_ch.ready  = 1'b0;
    steady          = 1'b0;
    hold_cycles     = 0;
    cycle_count     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset length of 12, field extremes, fill and evict past full
    foreach (directed_speeds[i]) send_speed(directed_speeds[i]);
    drain();

    // Random phases, one window length each
    foreach (phase_len[p]) begin
      write_window(phase_len[p]);
      steady = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_speed(rand_speed());
        // Long output hold-off while samples keep coming, so input backs up
        if ((p == 1 || p == 6) && n == 40) hold_cycles = 400;
      end
      drain();
    end
    steady = 1'b0;

    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** sliding_window_min_max_mean_core: PASSED **");
    end else begin
      $display("** sliding_window_min_max_mean_core: FAILED **");
    end
    $finish;
  end

endmodule
